>>> rtl/mlpsbt_pkg.sv
// ----------------------------------------------------------------------------
// mlpsbt_pkg
// shared constants, codes and types of the two-layer sigmoid trainer
// ----------------------------------------------------------------------------
package mlpsbt_pkg;

  // default sizes
  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_HIDDEN  = 16;
  localparam int DEF_MAX_OUTPUTS = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // stream widths
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;

  // apb widths
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register reset values
  localparam logic [16:0] LR_RESET  = 17'd6554;
  localparam logic [4:0]  CNT_RESET = 5'd16;

  // word kinds
  localparam logic [1:0] KIND_WR_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_RD_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_FEATURE   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
  localparam logic [1:0] REG_NUM_INPUTS  = 2'd1;
  localparam logic [1:0] REG_NUM_HIDDEN  = 2'd2;
  localparam logic [1:0] REG_NUM_OUTPUTS = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RDW   = 8'b0000_0010,
    ST_FWD_H = 8'b0000_0100,
    ST_FWD_O = 8'b0000_1000,
    ST_DLT_O = 8'b0001_0000,
    ST_DLT_H = 8'b0010_0000,
    ST_UPD_H = 8'b0100_0000,
    ST_UPD_O = 8'b1000_0000
  } state_t;

  typedef enum logic [4:0] {
    B_ISSUE = 5'b00001,
    B_MUL   = 5'b00010,
    B_ACC   = 5'b00100,
    B_FIN   = 5'b01000,
    B_WR    = 5'b10000
  } beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/mlpsbt_ram.sv
// ----------------------------------------------------------------------------
// mlpsbt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mlpsbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mlp_sigmoid_backprop_trainer_unit.sv
// ----------------------------------------------------------------------------
// mlp_sigmoid_backprop_trainer_unit
// two-layer sigmoid perceptron with one gradient step per training sample
// ----------------------------------------------------------------------------
// words arrive on the s_ channel: weight writes, weight reads and sample
// features (tlast marks the final feature). weight writes and plain features
// leave the sequencer idle, ready for the next word. a weight read puts one
// word on the m_ channel through the registered ram read and the output
// register, and input waits until that word is loaded. the final feature
// starts a run: hidden pass, then output pass, with each output activation
// leaving on m_ as its neuron finishes. a training run then goes on to the
// output and hidden deltas and the weight update of both layers. all products
// come from the single shared multiplier, and the weight rams have a
// registered read: each multiply-accumulate takes issue, multiply and
// accumulate beats.
// at reset the sequencer goes idle, the feature count clears and the
// registers take their defaults; ram contents stay undefined until written.
// a stalled receiver holds the output word; the run waits at the next
// activation until the word is taken. s_tready is high whenever idle.
// config is to be written over apb only while idle, which the block itself does not enforce; pready is always high.
// ----------------------------------------------------------------------------
module mlp_sigmoid_backprop_trainer_unit #(
  parameter int MAX_INPUTS  = mlpsbt_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN  = mlpsbt_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS = mlpsbt_pkg::DEF_MAX_OUTPUTS,
  parameter int FRAC_BITS   = mlpsbt_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // apb config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mlpsbt_pkg::APB_AW-1:0]    paddr,
  input  logic [mlpsbt_pkg::APB_DW-1:0]    pwdata,
  output logic [mlpsbt_pkg::APB_DW-1:0]    prdata,
  output logic                             pready,
  // input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // neuron_index[3:0], weight_index[8:4], sample_value[40:9],
  // class_label[44:41], train[45], zero fill
  input  logic [mlpsbt_pkg::S_TDATA_W-1:0] s_tdata,
  // kind[1:0], layer_select[2]
  input  logic [mlpsbt_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                             s_tlast,   // last_feature
  // result words
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result_value[31:0], result_index[35:32], zero fill
  output logic [mlpsbt_pkg::M_TDATA_W-1:0] m_tdata,
  // result_is_weight[0]
  output logic [mlpsbt_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                             m_tlast    // result_last
);
  import mlpsbt_pkg::*;

  // sizes
  localparam int HSLOTS  = MAX_INPUTS + 1;
  localparam int OSLOTS  = MAX_HIDDEN + 1;
  localparam int WH_D    = MAX_HIDDEN * HSLOTS;
  localparam int WO_D    = MAX_OUTPUTS * OSLOTS;
  localparam int DL_D    = MAX_HIDDEN + MAX_OUTPUTS;
  localparam int MAXALL0 = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int MAXALL  = (MAXALL0 > MAX_OUTPUTS) ? MAXALL0 : MAX_OUTPUTS;
  localparam int CW      = $clog2(MAXALL + 1);
  localparam int NO_MAX  = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
  localparam int WHA     = (WH_D > 1) ? $clog2(WH_D) : 1;
  localparam int WOA     = (WO_D > 1) ? $clog2(WO_D) : 1;
  localparam int FA      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HA      = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OA      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int DA      = $clog2(DL_D);
  localparam int FCW     = $clog2(MAX_INPUTS + 1);

  // sigmoid constants
  localparam logic [32:0]        ONE  = 33'd1 << FRAC_BITS;
  localparam logic [32:0]        T5   = 33'd5 * ONE;
  localparam logic [32:0]        T19  = (33'd19 * ONE) >> 3;
  localparam logic [32:0]        C27  = (33'd27 * ONE) >> 5;
  localparam logic [32:0]        C5   = (33'd5 * ONE) >> 3;
  localparam logic [32:0]        CH   = ONE >> 1;
  localparam logic signed [32:0] ONE_S = 33'sd1 <<< FRAC_BITS;

  // unpacked input fields
  logic [1:0]         in_kind;
  logic               in_layer;
  logic [3:0]         in_neuron;
  logic [4:0]         in_slot;
  logic signed [31:0] in_value;
  logic [3:0]         in_label;
  logic               in_train;

  assign in_kind   = s_tuser[1:0];
  assign in_layer  = s_tuser[2];
  assign in_neuron = s_tdata[3:0];
  assign in_slot   = s_tdata[8:4];
  assign in_value  = s_tdata[40:9];
  assign in_label  = s_tdata[44:41];
  assign in_train  = s_tdata[45];

  // config registers
  logic [16:0] learn_rate;
  logic [4:0]  num_in;
  logic [4:0]  num_hid;
  logic [4:0]  num_out;

  // sequencer state
  state_t             state;
  beat_t              beat;
  logic [CW-1:0]      j;
  logic [CW-1:0]      k;
  logic               have_e;
  logic               train_r;
  logic [3:0]         label_r;
  logic [FCW-1:0]     feat_cnt;
  logic               rd_ok;
  logic               rd_layer;
  logic [3:0]         rd_neuron;

  // datapath registers
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] w_d;
  logic signed [31:0] sum_sat;
  logic signed [31:0] deriv_r;
  logic signed [31:0] e_r;

  // output register
  logic               out_valid;
  logic signed [31:0] out_value;
  logic [3:0]         out_index;
  logic               out_is_w;
  logic               out_last;
  logic               out_free;
  logic               out_load;

  // ram ports
  logic               wh_we, wh_re, wo_we, wo_re, ft_we, ft_re;
  logic               ho_we, ho_re, ac_we, ac_re, dl_we, dl_re;
  logic [WHA-1:0]     wh_waddr, wh_raddr;
  logic [WOA-1:0]     wo_waddr, wo_raddr;
  logic [FA-1:0]      ft_waddr, ft_raddr;
  logic [HA-1:0]      ho_waddr, ho_raddr;
  logic [OA-1:0]      ac_waddr, ac_raddr;
  logic [DA-1:0]      dl_waddr, dl_raddr;
  logic [31:0]        wh_wdata, wo_wdata, ft_wdata, ho_wdata, ac_wdata, dl_wdata;
  logic signed [31:0] wh_rd, wo_rd, ft_rd, ho_rd, ac_rd, dl_rd;

  function automatic logic [CW-1:0] clampc(input logic [4:0] v, input int mx);
    if (v == 5'd0) return CW'(1);
    if (int'(v) > mx) return CW'(mx);
    return CW'(v);
  endfunction

  function automatic logic [WHA-1:0] wh_addr(input int n, input int s);
    return WHA'(n * HSLOTS + s);
  endfunction

  function automatic logic [WOA-1:0] wo_addr(input int n, input int s);
    return WOA'(n * OSLOTS + s);
  endfunction

  // piecewise linear sigmoid, taken from |x| and mirrored for negative x
  function automatic logic signed [31:0] sigm(input logic signed [31:0] x);
    logic [32:0] ax;
    logic [32:0] y;
    ax = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
    if (ax >= T5) y = ONE;
    else if (ax >= T19) y = (ax >> 5) + C27;
    else if (ax >= ONE) y = (ax >> 3) + C5;
    else y = (ax >> 2) + CH;
    if (x[31]) y = ONE - y;
    return y[31:0];
  endfunction

  // clamped counts in use
  logic [CW-1:0] ni, nh, no;
  assign ni = clampc(num_in, MAX_INPUTS);
  assign nh = clampc(num_hid, MAX_HIDDEN);
  assign no = clampc(num_out, NO_MAX);

  // fan-in and neuron count of the current pass
  logic [CW-1:0] fan, jmax;
  logic          at_fan, last_j;

  always_comb begin
    fan  = ni;
    jmax = nh;
    unique case (state)
      ST_FWD_O: begin fan = nh; jmax = no; end
      ST_DLT_O: begin fan = '0; jmax = no; end
      ST_DLT_H: begin fan = no; jmax = nh; end
      ST_UPD_O: begin fan = nh; jmax = no; end
      default:  begin fan = ni; jmax = nh; end
    endcase
  end

  assign at_fan = (k == fan);
  assign last_j = (j == jmax - CW'(1));

  // weight access range check and address for incoming words
  logic           in_ok;
  logic [WHA-1:0] in_wh_addr;
  logic [WOA-1:0] in_wo_addr;
  logic           accept;

  assign in_ok = in_layer ? (int'(in_neuron) < MAX_OUTPUTS && int'(in_slot) <= MAX_HIDDEN)
                          : (int'(in_neuron) < MAX_HIDDEN && int'(in_slot) <= MAX_INPUTS);
  assign in_wh_addr = wh_addr(int'(in_neuron), int'(in_slot));
  assign in_wo_addr = wo_addr(int'(in_neuron), int'(in_slot));
  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !out_valid || m_tready;
  // a read-back word or an activation enters the output register
  assign out_load   = out_free &&
                      ((state == ST_RDW) || (state == ST_FWD_O && beat == B_FIN));

  // datapath helpers
  logic signed [63:0] prod_sh;
  logic signed [31:0] upd_val;
  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] tgt;

  assign prod_sh = prod >>> FRAC_BITS;
  assign upd_val = at_fan ? sat32(64'(w_d) - 64'(e_r)) : sat32(64'(w_d) - prod_sh);
  assign tgt     = (int'(j) == int'(label_r)) ? ONE_S : 33'sd0;

  // multiplier operands
  always_comb begin
    mul_a = 33'(wh_rd);
    mul_b = 33'(ft_rd);
    unique case (state)
      ST_FWD_O: begin
        mul_a = 33'(wo_rd);
        mul_b = 33'(ho_rd);
      end
      ST_DLT_O: begin
        if (beat == B_FIN) begin
          mul_a = 33'(sum_sat);
          mul_b = 33'(deriv_r);
        end else begin
          mul_a = 33'(ac_rd);
          mul_b = ONE_S - 33'(ac_rd);
        end
      end
      ST_DLT_H: begin
        if (beat == B_FIN) begin
          mul_a = 33'(sum_sat);
          mul_b = 33'(deriv_r);
        end else if (at_fan) begin
          mul_a = 33'(ho_rd);
          mul_b = ONE_S - 33'(ho_rd);
        end else begin
          mul_a = 33'(wo_rd);
          mul_b = 33'(dl_rd);
        end
      end
      ST_UPD_H: begin
        mul_a = have_e ? 33'(e_r) : $signed({16'd0, learn_rate});
        mul_b = have_e ? 33'(ft_rd) : 33'(dl_rd);
      end
      ST_UPD_O: begin
        mul_a = have_e ? 33'(e_r) : $signed({16'd0, learn_rate});
        mul_b = have_e ? 33'(ho_rd) : 33'(dl_rd);
      end
      default: begin
        mul_a = 33'(wh_rd);
        mul_b = 33'(ft_rd);
      end
    endcase
  end

  // ram control
  always_comb begin
    wh_we = 1'b0; wo_we = 1'b0; ft_we = 1'b0;
    ho_we = 1'b0; ac_we = 1'b0; dl_we = 1'b0;
    wh_re = 1'b0; wo_re = 1'b0; ft_re = 1'b0;
    ho_re = 1'b0; ac_re = 1'b0; dl_re = 1'b0;

    wh_waddr = wh_addr(int'(j), int'(k));
    wh_raddr = wh_addr(int'(j), int'(k));
    wo_waddr = wo_addr(int'(j), int'(k));
    wo_raddr = (state == ST_DLT_H) ? wo_addr(int'(k), int'(j)) : wo_addr(int'(j), int'(k));
    ft_waddr = feat_cnt[FA-1:0];
    ft_raddr = k[FA-1:0];
    ho_waddr = j[HA-1:0];
    ho_raddr = (state == ST_DLT_H) ? j[HA-1:0] : k[HA-1:0];
    ac_waddr = j[OA-1:0];
    ac_raddr = j[OA-1:0];
    dl_waddr = (state == ST_DLT_O) ? DA'(MAX_HIDDEN + int'(j)) : DA'(j);
    dl_raddr = DA'(j);
    if (state == ST_DLT_H) dl_raddr = DA'(MAX_HIDDEN + int'(k));
    if (state == ST_UPD_O) dl_raddr = DA'(MAX_HIDDEN + int'(j));

    wh_wdata = upd_val;
    wo_wdata = upd_val;
    ft_wdata = in_value;
    ho_wdata = sigm(sum_sat);
    ac_wdata = sigm(sum_sat);
    dl_wdata = sat32(prod_sh);

    unique case (state)
      ST_IDLE: begin
        wh_waddr = in_wh_addr;
        wh_raddr = in_wh_addr;
        wo_waddr = in_wo_addr;
        wo_raddr = in_wo_addr;
        wh_wdata = in_value;
        wo_wdata = in_value;
        if (accept && in_ok && in_kind == KIND_WR_WEIGHT) begin
          wh_we = !in_layer;
          wo_we = in_layer;
        end
        if (accept && in_ok && in_kind == KIND_RD_WEIGHT) begin
          wh_re = !in_layer;
          wo_re = in_layer;
        end
        if (accept && in_kind == KIND_FEATURE && int'(feat_cnt) < MAX_INPUTS) begin
          ft_we = 1'b1;
        end
      end
      ST_FWD_H: begin
        wh_re = (beat == B_ISSUE);
        ft_re = (beat == B_ISSUE);
        ho_we = (beat == B_FIN);
      end
      ST_FWD_O: begin
        wo_re = (beat == B_ISSUE);
        ho_re = (beat == B_ISSUE);
        ac_we = (beat == B_FIN) && out_free;
      end
      ST_DLT_O: begin
        ac_re = (beat == B_ISSUE);
        dl_we = (beat == B_WR);
      end
      ST_DLT_H: begin
        wo_re = (beat == B_ISSUE) && !at_fan;
        dl_re = (beat == B_ISSUE) && !at_fan;
        ho_re = (beat == B_ISSUE) && at_fan;
        dl_we = (beat == B_WR);
      end
      ST_UPD_H: begin
        dl_re = (beat == B_ISSUE) && !have_e;
        wh_re = (beat == B_ISSUE) && have_e;
        ft_re = (beat == B_ISSUE) && have_e;
        wh_we = (beat == B_ACC) && have_e;
      end
      ST_UPD_O: begin
        dl_re = (beat == B_ISSUE) && !have_e;
        wo_re = (beat == B_ISSUE) && have_e;
        ho_re = (beat == B_ISSUE) && have_e;
        wo_we = (beat == B_ACC) && have_e;
      end
      default: begin
        wh_re = 1'b0;
      end
    endcase
  end

  // rams
  mlpsbt_ram #(.WIDTH(32), .DEPTH(WH_D)) u_wh_ram (
    .clk(clk), .we(wh_we), .waddr(wh_waddr), .wdata(wh_wdata),
    .re(wh_re), .raddr(wh_raddr), .rdata(wh_rd)
  );
  mlpsbt_ram #(.WIDTH(32), .DEPTH(WO_D)) u_wo_ram (
    .clk(clk), .we(wo_we), .waddr(wo_waddr), .wdata(wo_wdata),
    .re(wo_re), .raddr(wo_raddr), .rdata(wo_rd)
  );
  mlpsbt_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_ft_ram (
    .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
    .re(ft_re), .raddr(ft_raddr), .rdata(ft_rd)
  );
  mlpsbt_ram #(.WIDTH(32), .DEPTH(MAX_HIDDEN)) u_ho_ram (
    .clk(clk), .we(ho_we), .waddr(ho_waddr), .wdata(ho_wdata),
    .re(ho_re), .raddr(ho_raddr), .rdata(ho_rd)
  );
  mlpsbt_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_ac_ram (
    .clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
    .re(ac_re), .raddr(ac_raddr), .rdata(ac_rd)
  );
  mlpsbt_ram #(.WIDTH(32), .DEPTH(DL_D)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .re(dl_re), .raddr(dl_raddr), .rdata(dl_rd)
  );

  // apb
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_LEARN_RATE:  prdata = {15'd0, learn_rate};
      REG_NUM_INPUTS:  prdata = {27'd0, num_in};
      REG_NUM_HIDDEN:  prdata = {27'd0, num_hid};
      REG_NUM_OUTPUTS: prdata = {27'd0, num_out};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LR_RESET;
      num_in     <= CNT_RESET;
      num_hid    <= CNT_RESET;
      num_out    <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_LEARN_RATE:  learn_rate <= pwdata[16:0];
        REG_NUM_INPUTS:  num_in     <= pwdata[4:0];
        REG_NUM_HIDDEN:  num_hid    <= pwdata[4:0];
        REG_NUM_OUTPUTS: num_out    <= pwdata[4:0];
        default:         num_out    <= num_out;
      endcase
    end
  end

  // output word
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_index, out_value};
  assign m_tuser  = out_is_w;
  assign m_tlast  = out_last;

  // output valid: set on a load, cleared once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      beat      <= B_ISSUE;
      j         <= '0;
      k         <= '0;
      have_e    <= 1'b0;
      feat_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_ok     <= in_ok;
            rd_layer  <= in_layer;
            rd_neuron <= in_neuron;
            train_r   <= in_train;
            label_r   <= in_label;
            if (in_kind == KIND_RD_WEIGHT) begin
              state <= ST_RDW;
            end else if (in_kind == KIND_FEATURE) begin
              if (s_tlast) begin
                // sample complete: start the hidden pass
                feat_cnt <= '0;
                j        <= '0;
                k        <= '0;
                acc      <= '0;
                beat     <= B_ISSUE;
                state    <= ST_FWD_H;
              end else if (int'(feat_cnt) < MAX_INPUTS) begin
                feat_cnt <= feat_cnt + FCW'(1);
              end
            end
          end
        end

        ST_RDW: begin
          if (out_free) begin
            out_value <= rd_ok ? (rd_layer ? wo_rd : wh_rd) : 32'sd0;
            out_index <= rd_neuron;
            out_is_w  <= 1'b1;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          unique case (beat)
            B_ISSUE: beat <= B_MUL;

            B_MUL: begin
              prod <= 64'(mul_a) * 64'(mul_b);
              w_d  <= (state == ST_FWD_O || state == ST_UPD_O) ? wo_rd : wh_rd;
              if (state == ST_DLT_O) sum_sat <= 32'(33'(ac_rd) - tgt);
              beat <= B_ACC;
            end

            B_ACC: begin
              beat <= B_ISSUE;
              if (state == ST_FWD_H || state == ST_FWD_O) begin
                if (at_fan) begin
                  // bias closes the neuron sum
                  sum_sat <= sat32(acc + 64'(w_d));
                  beat    <= B_FIN;
                end else begin
                  acc <= acc + prod_sh;
                  k   <= k + CW'(1);
                end
              end else if (state == ST_DLT_O) begin
                deriv_r <= sat32(prod_sh);
                beat    <= B_FIN;
              end else if (state == ST_DLT_H) begin
                if (at_fan) begin
                  deriv_r <= sat32(prod_sh);
                  sum_sat <= sat32(acc);
                  beat    <= B_FIN;
                end else begin
                  acc <= acc + prod_sh;
                  k   <= k + CW'(1);
                end
              end else begin
                // weight update
                if (!have_e) begin
                  e_r    <= sat32(prod_sh);
                  have_e <= 1'b1;
                  k      <= '0;
                end else if (at_fan) begin
                  have_e <= 1'b0;
                  k      <= '0;
                  if (last_j) begin
                    j     <= '0;
                    state <= (state == ST_UPD_H) ? ST_UPD_O : ST_IDLE;
                  end else begin
                    j <= j + CW'(1);
                  end
                end else begin
                  k <= k + CW'(1);
                end
              end
            end

            B_FIN: begin
              if (state == ST_FWD_H) begin
                acc  <= '0;
                k    <= '0;
                beat <= B_ISSUE;
                if (last_j) begin
                  j     <= '0;
                  state <= ST_FWD_O;
                end else begin
                  j <= j + CW'(1);
                end
              end else if (state == ST_FWD_O) begin
                // activation leaves as soon as the output register is free
                if (out_free) begin
                  out_value <= sigm(sum_sat);
                  out_index <= j[3:0];
                  out_is_w  <= 1'b0;
                  out_last  <= last_j;
                  acc       <= '0;
                  k         <= '0;
                  beat      <= B_ISSUE;
                  if (last_j) begin
                    j     <= '0;
                    state <= train_r ? ST_DLT_O : ST_IDLE;
                  end else begin
                    j <= j + CW'(1);
                  end
                end
              end else begin
                prod <= 64'(mul_a) * 64'(mul_b);
                beat <= B_WR;
              end
            end

            B_WR: begin
              acc  <= '0;
              k    <= '0;
              beat <= B_ISSUE;
              if (last_j) begin
                j     <= '0;
                state <= (state == ST_DLT_O) ? ST_DLT_H : ST_UPD_H;
              end else begin
                j <= j + CW'(1);
              end
            end

            default: beat <= B_ISSUE;
          endcase
        end
      endcase
    end
  end

endmodule

>>> test/mlp_sigmoid_backprop_trainer_unit_tb.sv
// ----------------------------------------------------------------------------
// mlp_sigmoid_backprop_trainer_unit_tb
// self-checking bench for the two-layer sigmoid trainer
// ----------------------------------------------------------------------------
// loads the weight slots that the sizes in use can reach, then runs directed
// and random words (weight writes, reads, features and whole samples, with
// and without training) through the stream port. a fixed-point predictor in
// the bench tracks the weights and computes each expected result word, which
// is checked in order against the m_ channel. both sides stall in random
// bursts, and the sizes and learning rate are changed over apb between phases.
// ----------------------------------------------------------------------------
module mlp_sigmoid_backprop_trainer_unit_tb;
  import mlpsbt_pkg::*;

  localparam int NSLOT   = 17;
  localparam int SETTLE  = 6000;     // longest training run plus margin
  localparam int LIMIT   = 3000000;
  localparam int LOAD_N  = 4;        // neurons loaded in each layer
  localparam int LOAD_NI = 5;        // largest input count used
  localparam int LOAD_NH = 4;        // largest hidden count used
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        is_weight;
    logic        last;
  } result_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  mlp_sigmoid_backprop_trainer_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state: registers and stores at the block's widths
  logic [16:0] lrate;
  logic [4:0]  cnt_in, cnt_hid, cnt_out;
  int hid_w [0:16*NSLOT-1];
  int out_w [0:16*NSLOT-1];
  int feat [0:15];
  int feat_count;
  int hid_act [0:15];
  int out_act [0:15];

  result_t pending_results[$];
  int fails = 0;
  int cycles = 0;
  bit quiet = 0;          // no idling on either side in the final part

  // ---------------------------------------------------------------- arithmetic
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;   // floor toward minus infinity
  endfunction

  function automatic int sat_32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // piecewise sigmoid approximation
  function automatic int plan_sigmoid(int x);
    longint one, ax, y;
    one = 65536;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    if (ax >= 5 * one) y = one;
    else if (ax >= ((19 * one) >>> 3)) y = (ax >>> 5) + ((27 * one) >>> 5);
    else if (ax >= one) y = (ax >>> 3) + ((5 * one) >>> 3);
    else y = (ax >>> 2) + (one >>> 1);
    if (x < 0) y = one - y;
    return int'(y);
  endfunction

  function automatic int slope(int o);
    return sat_32(fx_mul(o, 65536 - longint'(o)));
  endfunction

  function automatic int clamp_cnt(logic [4:0] v);
    if (v == 0) return 1;
    return (v > 16) ? 16 : int'(v);
  endfunction

  // ---------------------------------------------------------------- predictor
  // one accepted input word: updates the trainer copy and queues its results
  task automatic predict_word(logic [1:0] kind, logic layer, logic [3:0] neuron,
                              logic [4:0] slot, int value, logic last,
                              logic [3:0] label, logic train);
    int ni, nh, no;
    longint acc, e;
    int odelta [0:15];
    int hdelta [0:15];
    result_t r;
    if (kind == KIND_WR_WEIGHT) begin
      if (slot <= 16) begin
        if (layer) out_w[neuron*NSLOT+slot] = value;
        else hid_w[neuron*NSLOT+slot] = value;
      end
    end else if (kind == KIND_RD_WEIGHT) begin
      r.value = (slot > 16) ? 0 : (layer ? out_w[neuron*NSLOT+slot]
                                         : hid_w[neuron*NSLOT+slot]);
      r.index = neuron;
      r.is_weight = 1;
      r.last = 1;
      pending_results = {pending_results, r};
    end else if (kind == KIND_FEATURE) begin
      if (feat_count < 16) begin
        feat[feat_count] = value;
        feat_count++;
      end
      if (last) begin
        feat_count = 0;
        ni = clamp_cnt(cnt_in);
        nh = clamp_cnt(cnt_hid);
        no = clamp_cnt(cnt_out);
        // forward pass
        for (int j = 0; j < nh; j++) begin
          acc = hid_w[j*NSLOT+ni];
          for (int k = 0; k < ni; k++) acc += fx_mul(hid_w[j*NSLOT+k], feat[k]);
          hid_act[j] = plan_sigmoid(sat_32(acc));
        end
        for (int j = 0; j < no; j++) begin
          acc = out_w[j*NSLOT+nh];
          for (int k = 0; k < nh; k++) acc += fx_mul(out_w[j*NSLOT+k], hid_act[k]);
          out_act[j] = plan_sigmoid(sat_32(acc));
          r.value = out_act[j];
          r.index = j[3:0];
          r.is_weight = 0;
          r.last = (j + 1 == no);
          pending_results = {pending_results, r};
        end
        if (train) begin
          // deltas from the weights before the step
          for (int j = 0; j < no; j++)
            odelta[j] = sat_32(fx_mul(longint'(out_act[j]) - ((j == label) ? 65536 : 0),
                                      slope(out_act[j])));
          for (int j = 0; j < nh; j++) begin
            acc = 0;
            for (int k = 0; k < no; k++) acc += fx_mul(out_w[k*NSLOT+j], odelta[k]);
            hdelta[j] = sat_32(fx_mul(sat_32(acc), slope(hid_act[j])));
          end
          // gradient step
          for (int j = 0; j < nh; j++) begin
            e = sat_32(fx_mul(longint'(lrate), hdelta[j]));
            for (int k = 0; k < ni; k++)
              hid_w[j*NSLOT+k] = sat_32(longint'(hid_w[j*NSLOT+k]) - fx_mul(e, feat[k]));
            hid_w[j*NSLOT+ni] = sat_32(longint'(hid_w[j*NSLOT+ni]) - e);
          end
          for (int j = 0; j < no; j++) begin
            e = sat_32(fx_mul(longint'(lrate), odelta[j]));
            for (int k = 0; k < nh; k++)
              out_w[j*NSLOT+k] = sat_32(longint'(out_w[j*NSLOT+k]) - fx_mul(e, hid_act[k]));
            out_w[j*NSLOT+nh] = sat_32(longint'(out_w[j*NSLOT+nh]) - e);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- drivers
  // idle burst before the word, then hold it until the handshake
  task automatic send_word(logic [1:0] kind, logic layer, logic [3:0] neuron,
                           logic [4:0] slot, int value, logic last,
                           logic [3:0] label, logic train);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk) s_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tuser  <= {layer, kind};
    s_tlast  <= last;
    s_tdata  <= {2'b00, train, label, value, slot, neuron};
    do @(posedge clk); while (!s_tready);
    predict_word(kind, layer, neuron, slot, value, last, label, train);
  endtask

  // drop valid and wait until every result is in and the block is idle
  task automatic settle();
    @(negedge clk) s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= APB_AW'(idx) << 2; pwdata <= val;
    @(negedge clk) penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_LEARN_RATE:  lrate   = val[16:0];
      REG_NUM_INPUTS:  cnt_in  = val[4:0];
      REG_NUM_HIDDEN:  cnt_hid = val[4:0];
      REG_NUM_OUTPUTS: cnt_out = val[4:0];
    endcase
  endtask

  task automatic configure(logic [31:0] lr, logic [31:0] ni, logic [31:0] nh,
                           logic [31:0] no);
    settle();
    write_reg(REG_LEARN_RATE, lr);
    write_reg(REG_NUM_INPUTS, ni);
    write_reg(REG_NUM_HIDDEN, nh);
    write_reg(REG_NUM_OUTPUTS, no);
  endtask

  // mostly modest q16.16 values, now and then the full range
  function automatic int pick_value();
    if ($urandom_range(0, 15) == 0) return int'($urandom);
    return $signed($urandom_range(0, 262143)) - 131072;
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(0, 31) == 0) return int'($urandom);
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_sample(int n, logic [3:0] label, logic train);
    for (int i = 0; i < n; i++)
      send_word(KIND_FEATURE, 1'($urandom_range(0, 1)), 4'($urandom), 5'($urandom),
                pick_value(), i == n - 1, label, train);
  endtask

  // ---------------------------------------------------------------- tests
  // every slot that the sizes used in this run can reach
  task automatic test_weight_load();
    for (int n = 0; n < LOAD_N; n++) begin
      for (int s = 0; s <= LOAD_NI; s++)
        send_word(KIND_WR_WEIGHT, 1'b0, n[3:0], s[4:0],
                  $signed($urandom_range(0, 65535)) - 32768, 0, 0, 0);
      for (int s = 0; s <= LOAD_NH; s++)
        send_word(KIND_WR_WEIGHT, 1'b1, n[3:0], s[4:0],
                  $signed($urandom_range(0, 65535)) - 32768, 0, 0, 0);
    end
  endtask

  task automatic test_directed();
    // full sample first so that every feature slot in use holds a value
    send_sample(LOAD_NI, 4'd0, 1'b0);
    // weight extremes, read back, then made modest again
    send_word(KIND_WR_WEIGHT, 0, 4'd15, 5'd16, 32'sh7fffffff, 0, 0, 0);
    send_word(KIND_RD_WEIGHT, 0, 4'd15, 5'd16, 0, 0, 0, 0);
    send_word(KIND_WR_WEIGHT, 1, 4'd0, 5'd0, 32'sh80000000, 0, 0, 0);
    send_word(KIND_RD_WEIGHT, 1, 4'd0, 5'd0, 0, 0, 0, 0);
    // slot beyond the fan-in: write ignored, read gives zero
    send_word(KIND_WR_WEIGHT, 1, 4'd3, 5'd31, 32'h12345678, 0, 0, 0);
    send_word(KIND_RD_WEIGHT, 1, 4'd3, 5'd31, 0, 0, 0, 0);
    send_word(KIND_RD_WEIGHT, 0, 4'd7, 5'd17, 0, 0, 0, 0);
    // unused kind is dropped
    send_word(KIND_UNUSED, 1, 4'd15, 5'd31, -1, 1, 4'd15, 1);
    // saturating features, training on
    send_word(KIND_FEATURE, 0, 0, 0, 32'sh7fffffff, 0, 4'd15, 1);
    send_word(KIND_FEATURE, 0, 0, 0, 32'sh80000000, 1, 4'd15, 1);
    send_word(KIND_WR_WEIGHT, 0, 4'd15, 5'd16, 32'sd100, 0, 0, 0);
    send_word(KIND_WR_WEIGHT, 1, 4'd0, 5'd0, -32'sd100, 0, 0, 0);
    // buffer overflow, then a short sample
    send_sample(17, 4'd2, 1'b1);
    send_sample(3, 4'd0, 1'b1);
  endtask

  task automatic test_random(int words);
    int sent, r, n;
    logic layer;
    logic [4:0] slot;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(0, 15);
      if (r < 2) begin
        send_word(KIND_WR_WEIGHT, 1'($urandom_range(0, 1)), 4'($urandom),
                  ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16)),
                  pick_weight(), 1'($urandom), 4'($urandom), 1'($urandom));
        sent++;
      end else if (r < 4) begin
        // loaded slots, or a slot beyond any fan-in
        layer = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) slot = 5'($urandom_range(17, 31));
        else slot = 5'($urandom_range(0, layer ? LOAD_NH : LOAD_NI));
        send_word(KIND_RD_WEIGHT, layer, 4'($urandom_range(0, LOAD_N - 1)), slot,
                  int'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
        sent++;
      end else if (r == 4) begin
        send_word(KIND_UNUSED, 1'($urandom), 4'($urandom), 5'($urandom), int'($urandom),
                  1'($urandom), 4'($urandom), 1'($urandom));
        sent++;
      end else begin
        n = $urandom_range(1, 7);
        send_sample(n, 4'($urandom), 1'($urandom));
        sent += n;
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) @(negedge clk) m_tready <= 1;
      if (!quiet) begin
        run = $urandom_range(1, 15);
        repeat (run) @(negedge clk) m_tready <= 0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[31:0] !== e.value) begin
          $error("result_value exp %h got %h", e.value, m_tdata[31:0]); fails++;
        end
        if (m_tdata[35:32] !== e.index) begin
          $error("result_index exp %0d got %0d", e.index, m_tdata[35:32]); fails++;
        end
        if (m_tuser[0] !== e.is_weight) begin
          $error("result_is_weight exp %b got %b", e.is_weight, m_tuser[0]); fails++;
        end
        if (m_tlast !== e.last) begin
          $error("result_last exp %b got %b", e.last, m_tlast); fails++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    lrate = LR_RESET;
    cnt_in = CNT_RESET; cnt_hid = CNT_RESET; cnt_out = CNT_RESET;
    feat_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    configure(6554, 4, 3, 3);
    test_weight_load();
    test_directed();
    test_random(12);
    configure(0, 1, 1, 1);
    test_random(8);
    configure(65536, 0, 0, 0);
    test_random(8);
    configure(131071, LOAD_NI, LOAD_NH, LOAD_N);
    test_random(10);
    configure($urandom_range(0, 65536), $urandom_range(1, LOAD_NI),
              $urandom_range(1, LOAD_NH), $urandom_range(1, LOAD_N));
    test_random(8);
    configure(6554, LOAD_NI, LOAD_NH, LOAD_N);
    quiet = 1;
    test_random(12);
    settle();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mlpsbt_pkg.sv
rtl/mlpsbt_ram.sv
rtl/mlp_sigmoid_backprop_trainer_unit.sv
test/mlp_sigmoid_backprop_trainer_unit_tb.sv
